### hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication, held off while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

### hw/rtl/fdc_pkg.sv
// Shared types, constants and codes of the fan duty curve controller
package fdc_pkg;

    localparam int TEMP_W   = 12;
    localparam int DUTY_W   = 7;
    localparam int MASK_W   = 8;
    localparam int SPEED_W  = 8;
    localparam int SYS_W    = 2;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 12;
    localparam int SPAN_W   = 12;
    localparam int NUM_W    = 19;
    localparam int QCNT_W   = 3;

    localparam logic [DUTY_W-1:0] DUTY_LIMIT = 7'd100;

    localparam logic signed [TEMP_W-1:0] RST_TEMP_OFF  = 12'sd640;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LOW  = 12'sd720;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_HIGH = 12'sd1120;
    localparam logic [DUTY_W-1:0]        RST_DUTY_MIN  = 7'd30;
    localparam logic [DUTY_W-1:0]        RST_DUTY_MAX  = 7'd100;
    localparam logic [MASK_W-1:0]        RST_TEMP_BITS = 8'd1;
    localparam logic [MASK_W-1:0]        RST_HUM_BITS  = 8'd2;

    localparam logic [CFG_AW-1:0] CFG_TEMP_OFF  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_TEMP_LOW  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TEMP_HIGH = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DUTY_MIN  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DUTY_MAX  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_TEMP_BITS = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_HUM_BITS  = 3'd6;

    localparam logic [SYS_W-1:0] SYS_OFF = 2'd0;
    localparam logic [SYS_W-1:0] SYS_RUN = 2'd1;

    typedef enum logic [1:0] {
        REQ_TEMP  = 2'd0,
        REQ_STATE = 2'd1,
        REQ_ALERT = 2'd2,
        REQ_SPEED = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic sum;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic interp;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
        return (d > DUTY_LIMIT) ? DUTY_LIMIT : d;
    endfunction

endpackage

### hw/rtl/fdc_ctrl.sv
// Sequencer of the fan duty controller: evaluate, multiply, sum, divide, commit
module fdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fdc_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output fdc_pkg::t_dp_cmd o_cmd
);

    fdc_pkg::t_state r_state;
    fdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = fdc_pkg::ST_EVAL;
            end
            fdc_pkg::ST_EVAL: begin
                n_state = i_sts.interp ? fdc_pkg::ST_MUL : fdc_pkg::ST_DONE;
            end
            fdc_pkg::ST_MUL: n_state = fdc_pkg::ST_SUM;
            fdc_pkg::ST_SUM: n_state = fdc_pkg::ST_DIV;
            fdc_pkg::ST_DIV: begin
                if (i_sts.div_last) n_state = fdc_pkg::ST_DONE;
            end
            fdc_pkg::ST_DONE: begin
                if (i_sts.out_free) n_state = fdc_pkg::ST_IDLE;
            end
            default: n_state = fdc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            fdc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            fdc_pkg::ST_EVAL: o_cmd.eval     = 1'b1;
            fdc_pkg::ST_MUL:  o_cmd.mul      = 1'b1;
            fdc_pkg::ST_SUM:  o_cmd.sum      = 1'b1;
            fdc_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            fdc_pkg::ST_DONE: o_cmd.commit   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### hw/rtl/fdc_datapath.sv
// Datapath: config registers, controller state, curve logic, divider, output word
module fdc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fdc_pkg::CFG_AW-1:0]           i_cfg_addr,
    input  logic [fdc_pkg::CFG_DW-1:0]           i_cfg_wdata,
    input  logic [1:0]                           i_req_type,
    input  logic signed [fdc_pkg::TEMP_W-1:0]    i_temp_c_q4,
    input  logic                                 i_temp_valid,
    input  logic [fdc_pkg::SYS_W-1:0]            i_new_system_state,
    input  logic [fdc_pkg::MASK_W-1:0]           i_new_alert_mask,
    input  logic [fdc_pkg::SPEED_W-1:0]          i_speed_request,
    input  logic                                 i_out_ready,
    input  fdc_pkg::t_dp_cmd                     i_cmd,
    output fdc_pkg::t_dp_sts                     o_sts,
    output logic                                 o_out_valid,
    output logic [fdc_pkg::DUTY_W-1:0]           o_duty_percent
);

    localparam int DW = fdc_pkg::DUTY_W;
    localparam int TW = fdc_pkg::TEMP_W;
    localparam int SW = fdc_pkg::SPAN_W;
    localparam int NW = fdc_pkg::NUM_W;

    // configuration
    logic signed [TW-1:0]          r_temp_off;
    logic signed [TW-1:0]          r_temp_low;
    logic signed [TW-1:0]          r_temp_high;
    logic [DW-1:0]                 r_duty_min;
    logic [DW-1:0]                 r_duty_max;
    logic [fdc_pkg::MASK_W-1:0]    r_temp_bits;
    logic [fdc_pkg::MASK_W-1:0]    r_hum_bits;

    // controller state
    logic [DW-1:0]                 r_cur_duty;
    logic [fdc_pkg::SYS_W-1:0]     r_sys;
    logic [fdc_pkg::MASK_W-1:0]    r_mask;

    // latched word
    fdc_pkg::t_req                 r_req;
    logic signed [TW-1:0]          r_temp;
    logic                          r_tvalid;
    logic [fdc_pkg::SYS_W-1:0]     r_nsys;
    logic [fdc_pkg::MASK_W-1:0]    r_nmask;
    logic [fdc_pkg::SPEED_W-1:0]   r_speed;

    // working registers
    logic [DW-1:0]                 r_res;
    logic                          r_interp;
    logic [SW-1:0]                 r_span;
    logic [NW-1:0]                 r_p1;
    logic signed [NW+1:0]          r_p2;
    logic [NW-1:0]                 r_rem;
    logic [DW-1:0]                 r_q;
    logic [fdc_pkg::QCNT_W-1:0]    r_cnt;

    logic                          r_out_valid;
    logic [DW-1:0]                 r_out_duty;

    logic [DW-1:0]                 dmin;
    logic [DW-1:0]                 dmax;
    logic [DW-1:0]                 hold;
    logic [DW-1:0]                 n_res;
    logic                          n_interp;
    logic signed [TW:0]            span_full;
    logic signed [TW:0]            diff_full;
    logic signed [DW:0]            dslope;
    logic [NW-1:0]                 p1;
    logic signed [NW+1:0]          p2;
    logic signed [NW+1:0]          num_full;
    logic [NW-1:0]                 trial;
    logic                          q_bit;
    logic [DW-1:0]                 final_duty;
    logic                          out_free;

    assign dmin = fdc_pkg::clamp_duty(r_duty_min);
    assign dmax = fdc_pkg::clamp_duty(r_duty_max);
    assign hold = (r_cur_duty != '0) ? dmin : '0;

    always_comb begin
        n_res    = r_cur_duty;
        n_interp = 1'b0;
        unique case (r_req)
            fdc_pkg::REQ_TEMP: begin
                priority if ((r_mask & r_temp_bits) != '0) begin
                    n_res = dmax;
                end else if (r_sys == fdc_pkg::SYS_OFF) begin
                    n_res = '0;
                end else if (r_sys != fdc_pkg::SYS_RUN) begin
                    n_res = ((r_mask & r_hum_bits) != '0) ? dmin : '0;
                end else if (!r_tvalid) begin
                    n_res = hold;
                end else if (r_temp <= r_temp_off) begin
                    n_res = '0;
                end else if (r_temp <= r_temp_low) begin
                    n_res = hold;
                end else if (r_temp >= r_temp_high) begin
                    n_res = dmax;
                end else begin
                    n_res    = '0;
                    n_interp = 1'b1;
                end
            end
            fdc_pkg::REQ_STATE: n_res = (r_nsys == fdc_pkg::SYS_OFF) ? '0 : r_cur_duty;
            fdc_pkg::REQ_ALERT: n_res = r_cur_duty;
            fdc_pkg::REQ_SPEED: begin
                n_res = (r_speed > fdc_pkg::SPEED_W'(fdc_pkg::DUTY_LIMIT)) ?
                        fdc_pkg::DUTY_LIMIT : r_speed[DW-1:0];
            end
            default: n_res = r_cur_duty;
        endcase
    end

    // low < T < high here, so span and T - low are positive and below 4096
    assign span_full = {r_temp_high[TW-1], r_temp_high} - {r_temp_low[TW-1], r_temp_low};
    assign diff_full = {r_temp[TW-1], r_temp} - {r_temp_low[TW-1], r_temp_low};
    assign dslope    = $signed({1'b0, dmax}) - $signed({1'b0, dmin});
    assign p1        = NW'(dmin) * NW'(span_full[SW-1:0]);
    assign p2        = (NW+2)'($signed({1'b0, diff_full[SW-1:0]})) * (NW+2)'(dslope);
    assign num_full  = $signed({2'b00, r_p1}) + r_p2;

    // restoring divide, quotient known to stay at or below 100
    assign trial = NW'({{(NW-SW){1'b0}}, r_span} << r_cnt);
    assign q_bit = (r_rem >= trial);

    assign final_duty = r_interp ? fdc_pkg::clamp_duty(r_q) : r_res;
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_sts.interp   = n_interp;
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_off  <= fdc_pkg::RST_TEMP_OFF;
            r_temp_low  <= fdc_pkg::RST_TEMP_LOW;
            r_temp_high <= fdc_pkg::RST_TEMP_HIGH;
            r_duty_min  <= fdc_pkg::RST_DUTY_MIN;
            r_duty_max  <= fdc_pkg::RST_DUTY_MAX;
            r_temp_bits <= fdc_pkg::RST_TEMP_BITS;
            r_hum_bits  <= fdc_pkg::RST_HUM_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fdc_pkg::CFG_TEMP_OFF:  r_temp_off  <= $signed(i_cfg_wdata);
                fdc_pkg::CFG_TEMP_LOW:  r_temp_low  <= $signed(i_cfg_wdata);
                fdc_pkg::CFG_TEMP_HIGH: r_temp_high <= $signed(i_cfg_wdata);
                fdc_pkg::CFG_DUTY_MIN:  r_duty_min  <= i_cfg_wdata[DW-1:0];
                fdc_pkg::CFG_DUTY_MAX:  r_duty_max  <= i_cfg_wdata[DW-1:0];
                fdc_pkg::CFG_TEMP_BITS: r_temp_bits <= i_cfg_wdata[fdc_pkg::MASK_W-1:0];
                fdc_pkg::CFG_HUM_BITS:  r_hum_bits  <= i_cfg_wdata[fdc_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_duty  <= '0;
            r_sys       <= fdc_pkg::SYS_OFF;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_cur_duty  <= final_duty;
                r_out_valid <= 1'b1;
                if (r_req == fdc_pkg::REQ_STATE) r_sys  <= r_nsys;
                if (r_req == fdc_pkg::REQ_ALERT) r_mask <= r_nmask;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= fdc_pkg::t_req'(i_req_type);
            r_temp   <= i_temp_c_q4;
            r_tvalid <= i_temp_valid;
            r_nsys   <= i_new_system_state;
            r_nmask  <= i_new_alert_mask;
            r_speed  <= i_speed_request;
        end
        if (i_cmd.eval) begin
            r_res    <= n_res;
            r_interp <= n_interp;
        end
        if (i_cmd.mul) begin
            r_span <= span_full[SW-1:0];
            r_p1   <= p1;
            r_p2   <= p2;
        end
        if (i_cmd.sum) begin
            r_rem <= num_full[NW-1:0];
            r_q   <= '0;
            r_cnt <= fdc_pkg::QCNT_W'(DW - 1);
        end
        if (i_cmd.div_step) begin
            if (q_bit) r_rem <= r_rem - trial;
            r_q[r_cnt] <= q_bit;
            r_cnt      <= r_cnt - 1'b1;
        end
        if (i_cmd.commit) begin
            r_out_duty <= final_duty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_duty_percent = r_out_duty;

endmodule

### hw/rtl/fan_duty_curve_controller.sv
// Top level of the fan duty curve controller
// Usage:
//   Input channel i_in_valid / o_in_ready carries one request word (type,
//   temperature, valid flag, new state, new alert mask, speed request).
//   Output channel o_out_valid / i_out_ready returns one word per request:
//   the fan duty in percent after that request.
//   Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata),
//   registers 0..6, writes to other indexes are dropped; write only while idle.
// Sequence:
//   A word is taken in the idle state, evaluated the next cycle and then
//   committed to the output register once that register is free; the next
//   word is taken only after that commit. A temperature update on the linear
//   part of the curve adds a multiply step, a sum step and the restoring
//   divider, which forms the 7 quotient bits, before the commit.
// Reset: synchronous, active low; config returns to its defaults, duty 0,
//   state power off, alert mask 0, no output word pending.
// Stall: the output register holds its word; one further request is taken and
//   worked on, and waits in the commit step until the output register frees.
module fan_duty_curve_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fdc_pkg::CFG_AW-1:0]           i_cfg_addr,
    input  logic [fdc_pkg::CFG_DW-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_req_type,
    input  logic signed [fdc_pkg::TEMP_W-1:0]    i_temp_c_q4,
    input  logic                                 i_temp_valid,
    input  logic [fdc_pkg::SYS_W-1:0]            i_new_system_state,
    input  logic [fdc_pkg::MASK_W-1:0]           i_new_alert_mask,
    input  logic [fdc_pkg::SPEED_W-1:0]          i_speed_request,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [fdc_pkg::DUTY_W-1:0]           o_duty_percent
);

    fdc_pkg::t_dp_cmd cmd;
    fdc_pkg::t_dp_sts sts;

    fdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    fdc_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_req_type         (i_req_type),
        .i_temp_c_q4        (i_temp_c_q4),
        .i_temp_valid       (i_temp_valid),
        .i_new_system_state (i_new_system_state),
        .i_new_alert_mask   (i_new_alert_mask),
        .i_speed_request    (i_speed_request),
        .i_out_ready        (i_out_ready),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_duty_percent     (o_duty_percent)
    );

endmodule

### hw/rtl/fdc_checker.sv
// Port-level checker of the fan duty controller and its bind
`include "assert_macros.svh"

module fdc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [fdc_pkg::DUTY_W-1:0]  o_duty_percent
);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_duty_percent))
    `ASSERT_IMP(a_duty_range, i_clk, i_rst_n, o_out_valid, o_duty_percent <= fdc_pkg::DUTY_LIMIT)
    `ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind fan_duty_curve_controller fdc_checker u_fdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_duty_percent (o_duty_percent)
);
